[hdl/mdm_pkg.sv]
// Shared types and constants for the mecanum drive mixer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mdm_pkg;

	localparam int CFG_W      = 7;
	localparam int PADDR_W    = 5;
	localparam int APB_DATA_W = 32;

	localparam int DIV_STEPS  = 7;
	localparam int DIV_NUM_W  = 16;
	localparam int DIV_DEN_W  = 9;

	localparam int AXIS_STAGES = 5 + 2 * DIV_STEPS;
	localparam int MIX_STAGES  = 4;
	localparam int NORM_STAGES = 2 + DIV_STEPS;
	localparam int PIPE_STAGES = AXIS_STAGES + MIX_STAGES + NORM_STAGES;

	localparam int WHEELS = 4;

	typedef logic [CFG_W-1:0] cfg_val_t;

	typedef struct packed {
		cfg_val_t joy_deadband;
		cfg_val_t joy_full_scale;
		cfg_val_t power_limit;
		cfg_val_t drive_max;
		cfg_val_t strafe_max;
		cfg_val_t rotate_max;
	} cfg_t;

	typedef enum logic [PADDR_W-3:0] {
		REG_JOY_DEADBAND   = 3'd0,
		REG_JOY_FULL_SCALE = 3'd1,
		REG_POWER_LIMIT    = 3'd2,
		REG_DRIVE_MAX      = 3'd3,
		REG_STRAFE_MAX     = 3'd4,
		REG_ROTATE_MAX     = 3'd5
	} reg_idx_t;

	localparam cfg_t CFG_RESET = '{
		joy_deadband:   7'd10,
		joy_full_scale: 7'd127,
		power_limit:    7'd100,
		drive_max:      7'd100,
		strafe_max:     7'd100,
		rotate_max:     7'd100
	};

	typedef logic signed [7:0] axis_t;
	typedef logic signed [7:0] power_t;

	typedef logic [DIV_NUM_W-1:0] div_num_t;
	typedef logic [DIV_DEN_W-1:0] div_den_t;
	typedef logic [DIV_STEPS-1:0] div_quo_t;
	typedef logic                 div_tag_t;

	localparam div_den_t DEN_ONE = div_den_t'(1);

	typedef logic signed [9:0] wheel_sum_t;
	typedef logic [8:0]        wheel_mag_t;

	typedef struct packed {
		logic       neg;
		wheel_mag_t mag;
	} wheel_t;

endpackage

`default_nettype wire

[hdl/mdm_div.sv]
// Pipelined restoring divider, one quotient bit per stage, quotient below 2**DIV_STEPS.
// Depends on mdm_pkg.
`default_nettype none

module mdm_div import mdm_pkg::*; (
	input  logic                 clk,
	input  logic [DIV_STEPS:1]   adv,
	input  div_num_t             num,
	input  div_den_t             den,
	input  div_tag_t             tag,
	output div_quo_t             quo,
	output div_tag_t             tag_out
);

	div_num_t rem_s [DIV_STEPS-1:1];
	div_den_t den_s [DIV_STEPS-1:1];
	div_quo_t quo_s [DIV_STEPS:1];
	div_tag_t tag_s [DIV_STEPS:1];

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		localparam int B = DIV_STEPS - k;
		div_num_t           rem_i;
		div_den_t           den_i;
		div_quo_t           quo_i;
		div_tag_t           tag_i;
		div_quo_t           quo_n;
		logic [DIV_NUM_W:0] trial;

		if (k == 1) begin : g_first
			assign rem_i = num;
			assign den_i = den;
			assign quo_i = '0;
			assign tag_i = tag;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign quo_i = quo_s[k-1];
			assign tag_i = tag_s[k-1];
		end

		assign trial = {1'b0, rem_i}
			- ({{(DIV_NUM_W + 1 - DIV_DEN_W){1'b0}}, den_i} << B);

		always_comb begin
			quo_n    = quo_i;
			quo_n[B] = ~trial[DIV_NUM_W];
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				quo_s[k] <= quo_n;
				tag_s[k] <= tag_i;
			end
		end

		if (k < DIV_STEPS) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv[k]) begin
					rem_s[k] <= trial[DIV_NUM_W] ? rem_i : trial[DIV_NUM_W-1:0];
					den_s[k] <= den_i;
				end
			end
		end
	end

	assign quo     = quo_s[DIV_STEPS];
	assign tag_out = tag_s[DIV_STEPS];

endmodule

`default_nettype wire

[hdl/mdm_axis_lane.sv]
// One joystick axis: deadband, linear map to motor power, rescale to the axis maximum.
// Depends on mdm_pkg and mdm_div.
`default_nettype none

module mdm_axis_lane import mdm_pkg::*; (
	input  logic                 clk,
	input  logic [AXIS_STAGES:1] adv,
	input  cfg_t                 cfg,
	input  cfg_val_t             axis_max,
	input  axis_t                axis,
	output power_t               power
);

	localparam int ST_NUM1 = 3;
	localparam int D1_LO   = ST_NUM1 + 1;
	localparam int ST_NUM2 = D1_LO + DIV_STEPS;
	localparam int D2_LO   = ST_NUM2 + 1;

	axis_t                raw_s1;
	logic                 neg_s2;
	logic                 zero_s2;
	logic                 full_s2;
	cfg_val_t             diff_s2;
	div_num_t             num_s3;
	div_den_t             den_s3;
	div_tag_t             neg_s3;
	div_num_t             num_s11;
	div_den_t             den_s11;
	div_tag_t             neg_s11;
	power_t               power_s19;

	logic [7:0]           mag;
	cfg_val_t             span;
	logic [2*CFG_W-1:0]   prod1;
	logic [2*CFG_W-1:0]   prod2;
	div_quo_t             quo1;
	div_tag_t             tag1;
	div_quo_t             quo2;
	div_tag_t             tag2;
	logic                 gt;
	logic                 mm_zero;

	assign mag     = raw_s1[7] ? (8'd0 - raw_s1) : raw_s1;
	assign span    = cfg.joy_full_scale - cfg.joy_deadband;
	assign prod1   = diff_s2 * cfg.power_limit;
	assign prod2   = quo1 * axis_max;
	assign gt      = quo1 > cfg.power_limit;
	assign mm_zero = cfg.power_limit == '0;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			raw_s1 <= axis;
		end
		if (adv[2]) begin
			neg_s2  <= raw_s1[7];
			zero_s2 <= mag < {1'b0, cfg.joy_deadband};
			full_s2 <= (mag > {1'b0, cfg.joy_full_scale})
				|| (cfg.joy_full_scale == cfg.joy_deadband);
			diff_s2 <= mag[CFG_W-1:0] - cfg.joy_deadband;
		end
		// zero and full fold into the divider as n/1
		if (adv[ST_NUM1]) begin
			neg_s3 <= neg_s2;
			if (zero_s2) begin
				num_s3 <= '0;
				den_s3 <= DEN_ONE;
			end else if (full_s2) begin
				num_s3 <= div_num_t'(cfg.power_limit);
				den_s3 <= DEN_ONE;
			end else begin
				num_s3 <= div_num_t'(prod1);
				den_s3 <= div_den_t'(span);
			end
		end
		if (adv[ST_NUM2]) begin
			neg_s11 <= tag1;
			if (mm_zero) begin
				num_s11 <= '0;
				den_s11 <= DEN_ONE;
			end else if (gt) begin
				num_s11 <= div_num_t'(axis_max);
				den_s11 <= DEN_ONE;
			end else begin
				num_s11 <= div_num_t'(prod2);
				den_s11 <= div_den_t'(cfg.power_limit);
			end
		end
		if (adv[AXIS_STAGES]) begin
			power_s19 <= tag2 ? power_t'(8'd0 - {1'b0, quo2}) : power_t'({1'b0, quo2});
		end
	end

	mdm_div u_div_joy (
		.clk     (clk),
		.adv     (adv[D1_LO+DIV_STEPS-1:D1_LO]),
		.num     (num_s3),
		.den     (den_s3),
		.tag     (neg_s3),
		.quo     (quo1),
		.tag_out (tag1)
	);

	mdm_div u_div_axis (
		.clk     (clk),
		.adv     (adv[D2_LO+DIV_STEPS-1:D2_LO]),
		.num     (num_s11),
		.den     (den_s11),
		.tag     (neg_s11),
		.quo     (quo2),
		.tag_out (tag2)
	);

	assign power = power_s19;

endmodule

`default_nettype wire

[hdl/mdm_mixer.sv]
// Wheel sums from the three axis powers, magnitudes, and the peak magnitude.
// Depends on mdm_pkg.
`default_nettype none

module mdm_mixer import mdm_pkg::*; (
	input  logic                clk,
	input  logic [MIX_STAGES:1] adv,
	input  power_t              fwd,
	input  power_t              side,
	input  power_t              turn,
	output wheel_t              wheel [WHEELS],
	output wheel_mag_t          peak
);

	wheel_sum_t p_s1   [WHEELS];
	wheel_t     whl_s2 [WHEELS];
	wheel_t     whl_s3 [WHEELS];
	wheel_t     whl_s4 [WHEELS];
	wheel_mag_t pk01_s3;
	wheel_mag_t pk23_s3;
	wheel_mag_t peak_s4;

	wheel_sum_t f;
	wheel_sum_t s;
	wheel_sum_t r;

	assign f = wheel_sum_t'(fwd);
	assign s = wheel_sum_t'(side);
	assign r = wheel_sum_t'(turn);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			p_s1[0] <=  f + s + r;
			p_s1[1] <= -f + s + r;
			p_s1[2] <=  f - s + r;
			p_s1[3] <= -f - s + r;
		end
		if (adv[2]) begin
			for (int i = 0; i < WHEELS; i++) begin
				whl_s2[i].neg <= p_s1[i][9];
				whl_s2[i].mag <= p_s1[i][9] ? wheel_mag_t'(-p_s1[i]) : wheel_mag_t'(p_s1[i]);
			end
		end
		if (adv[3]) begin
			whl_s3  <= whl_s2;
			pk01_s3 <= (whl_s2[0].mag > whl_s2[1].mag) ? whl_s2[0].mag : whl_s2[1].mag;
			pk23_s3 <= (whl_s2[2].mag > whl_s2[3].mag) ? whl_s2[2].mag : whl_s2[3].mag;
		end
		if (adv[4]) begin
			whl_s4  <= whl_s3;
			peak_s4 <= (pk01_s3 > pk23_s3) ? pk01_s3 : pk23_s3;
		end
	end

	assign wheel = whl_s4;
	assign peak  = peak_s4;

endmodule

`default_nettype wire

[hdl/mdm_norm_lane.sv]
// One wheel: scale by power_limit/peak when the peak exceeds power_limit, sign last.
// Depends on mdm_pkg and mdm_div.
`default_nettype none

module mdm_norm_lane import mdm_pkg::*; (
	input  logic                 clk,
	input  logic [NORM_STAGES:1] adv,
	input  cfg_val_t             power_limit,
	input  wheel_t               wheel,
	input  wheel_mag_t           peak,
	output power_t               result
);

	div_num_t num_s1;
	div_den_t den_s1;
	div_tag_t neg_s1;
	power_t   result_s9;

	div_num_t prod;
	logic     norm;
	div_quo_t quo;
	div_tag_t neg;

	assign prod = wheel.mag * power_limit;
	assign norm = peak > wheel_mag_t'(power_limit);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			neg_s1 <= wheel.neg;
			if (norm) begin
				num_s1 <= prod;
				den_s1 <= div_den_t'(peak);
			end else begin
				num_s1 <= div_num_t'(wheel.mag);
				den_s1 <= DEN_ONE;
			end
		end
		if (adv[NORM_STAGES]) begin
			result_s9 <= neg ? power_t'(8'd0 - {1'b0, quo}) : power_t'({1'b0, quo});
		end
	end

	mdm_div u_div (
		.clk     (clk),
		.adv     (adv[DIV_STEPS+1:2]),
		.num     (num_s1),
		.den     (den_s1),
		.tag     (neg_s1),
		.quo     (quo),
		.tag_out (neg)
	);

	assign result = result_s9;

endmodule

`default_nettype wire

[hdl/mecanum_drive_mixer.sv]
// Mecanum drive mixer top level: register file, pipeline control, lanes.
// Depends on mdm_pkg, mdm_axis_lane, mdm_mixer, mdm_norm_lane.
//
// Input channel (in_valid/in_stall) carries one word of three signed joystick
// axes; output channel (out_valid/out_stall) carries one word of four signed
// wheel powers. A word is taken on an edge with valid high and stall low.
// Throughput is one word per cycle while the output is not stalled; the
// pipeline length is mostly set by the three 7-step pipelined dividers in
// series (joystick map, axis rescale, wheel normalization).
// Each stage holds its own valid bit and loads unless the output is stalled
// and it and every later stage are full, so while the output is stalled,
// input words enter until every stage is full; only then does in_stall go high.
// Registers sit on an APB port at byte address 4*index; pready is always high.
// Reset clears all valid bits and loads the register defaults (deadband 10,
// full scale 127, all power limits 100). The user must write registers only
// while the pipeline is empty; the block itself does not enforce it.
`default_nettype none

module mecanum_drive_mixer import mdm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  axis_t                 fwd_axis,
	input  axis_t                 side_axis,
	input  axis_t                 turn_axis,

	output logic                  out_valid,
	input  logic                  out_stall,
	output power_t                front_left,
	output power_t                front_right,
	output power_t                back_left,
	output power_t                back_right
);

	localparam int MIX_LO  = AXIS_STAGES + 1;
	localparam int NORM_LO = AXIS_STAGES + MIX_STAGES + 1;

	cfg_t                   cfg_q;
	cfg_val_t               rd_val;
	logic                   cfg_wr;
	reg_idx_t               reg_idx;

	logic [PIPE_STAGES:1]   vld_q;
	logic [PIPE_STAGES:1]   adv;

	power_t                 pwr_fwd;
	power_t                 pwr_side;
	power_t                 pwr_turn;
	wheel_t                 wheel [WHEELS];
	wheel_mag_t             peak;
	power_t                 result [WHEELS];

	// register file
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_JOY_DEADBAND:   cfg_q.joy_deadband   <= pwdata[CFG_W-1:0];
				REG_JOY_FULL_SCALE: cfg_q.joy_full_scale <= pwdata[CFG_W-1:0];
				REG_POWER_LIMIT:    cfg_q.power_limit    <= pwdata[CFG_W-1:0];
				REG_DRIVE_MAX:      cfg_q.drive_max      <= pwdata[CFG_W-1:0];
				REG_STRAFE_MAX:     cfg_q.strafe_max     <= pwdata[CFG_W-1:0];
				REG_ROTATE_MAX:     cfg_q.rotate_max     <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_JOY_DEADBAND:   rd_val = cfg_q.joy_deadband;
			REG_JOY_FULL_SCALE: rd_val = cfg_q.joy_full_scale;
			REG_POWER_LIMIT:    rd_val = cfg_q.power_limit;
			REG_DRIVE_MAX:      rd_val = cfg_q.drive_max;
			REG_STRAFE_MAX:     rd_val = cfg_q.strafe_max;
			REG_ROTATE_MAX:     rd_val = cfg_q.rotate_max;
			default:            rd_val = '0;
		endcase
	end

	assign prdata = {{(APB_DATA_W - CFG_W){1'b0}}, rd_val};

	// pipeline control: load when out_stall is low or this or a later stage has room
	for (genvar k = 1; k <= PIPE_STAGES; k++) begin : g_adv
		assign adv[k] = ~out_stall | ~(&vld_q[PIPE_STAGES:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= PIPE_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = ~adv[1];
	assign out_valid = vld_q[PIPE_STAGES];

	// datapath
	mdm_axis_lane u_lane_fwd (
		.clk      (clk),
		.adv      (adv[AXIS_STAGES:1]),
		.cfg      (cfg_q),
		.axis_max (cfg_q.drive_max),
		.axis     (fwd_axis),
		.power    (pwr_fwd)
	);

	mdm_axis_lane u_lane_side (
		.clk      (clk),
		.adv      (adv[AXIS_STAGES:1]),
		.cfg      (cfg_q),
		.axis_max (cfg_q.strafe_max),
		.axis     (side_axis),
		.power    (pwr_side)
	);

	mdm_axis_lane u_lane_turn (
		.clk      (clk),
		.adv      (adv[AXIS_STAGES:1]),
		.cfg      (cfg_q),
		.axis_max (cfg_q.rotate_max),
		.axis     (turn_axis),
		.power    (pwr_turn)
	);

	mdm_mixer u_mixer (
		.clk   (clk),
		.adv   (adv[NORM_LO-1:MIX_LO]),
		.fwd   (pwr_fwd),
		.side  (pwr_side),
		.turn  (pwr_turn),
		.wheel (wheel),
		.peak  (peak)
	);

	for (genvar i = 0; i < WHEELS; i++) begin : g_norm
		mdm_norm_lane u_norm (
			.clk         (clk),
			.adv         (adv[PIPE_STAGES:NORM_LO]),
			.power_limit (cfg_q.power_limit),
			.wheel       (wheel[i]),
			.peak        (peak),
			.result      (result[i])
		);
	end

	assign front_left  = result[0];
	assign front_right = result[1];
	assign back_left   = result[2];
	assign back_right  = result[3];

endmodule

`default_nettype wire

[test/tb_top.sv]
// Testbench for mecanum_drive_mixer: directed and random joystick words,
// checked field by field against a behavioral wheel-power predictor.
// Depends on mdm_pkg and the mecanum_drive_mixer RTL.

module tb_top import mdm_pkg::*;;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		power_t fl;
		power_t fr;
		power_t bl;
		power_t br;
	} wheel_cmd_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	axis_t fwd_axis;
	axis_t side_axis;
	axis_t turn_axis;
	logic out_valid;
	logic out_stall;
	power_t front_left;
	power_t front_right;
	power_t back_left;
	power_t back_right;

	cfg_t mix_cfg;
	wheel_cmd_t expected_wheels[$];
	int err_count = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;

	mecanum_drive_mixer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.fwd_axis   (fwd_axis),
		.side_axis  (side_axis),
		.turn_axis  (turn_axis),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.front_left (front_left),
		.front_right(front_right),
		.back_left  (back_left),
		.back_right (back_right)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout, %0d words outstanding", $time, expected_wheels.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// joystick deadband/full-scale map, then rescale onto the axis limit
	function automatic int axis_power_of(axis_t raw, cfg_val_t lim);
		int a, m, s, db, fs, mm, lm;
		db = mix_cfg.joy_deadband;
		fs = mix_cfg.joy_full_scale;
		mm = mix_cfg.power_limit;
		lm = lim;
		a = (raw < 0) ? -int'(raw) : int'(raw);
		if (a < db)
			m = 0;
		else if (a > fs || fs == db)
			m = mm;
		else
			m = (a - db) * mm / (fs - db);
		if (mm == 0)
			s = 0;
		else if (m > mm)
			s = lm;
		else
			s = m * lm / mm;
		return (raw < 0) ? -s : s;
	endfunction

	function automatic wheel_cmd_t mix_predict(axis_t f_in, axis_t s_in, axis_t t_in);
		int f, s, r, mx, mm, mg;
		int p[4];
		wheel_cmd_t w;
		f = axis_power_of(f_in, mix_cfg.drive_max);
		s = axis_power_of(s_in, mix_cfg.strafe_max);
		r = axis_power_of(t_in, mix_cfg.rotate_max);
		p[0] = f + s + r;
		p[1] = -f + s + r;
		p[2] = f - s + r;
		p[3] = -f - s + r;
		mm = mix_cfg.power_limit;
		mx = 0;
		for (int i = 0; i < 4; i++) begin
			mg = (p[i] < 0) ? -p[i] : p[i];
			if (mg > mx)
				mx = mg;
		end
		if (mx > mm) begin
			for (int i = 0; i < 4; i++) begin
				mg = ((p[i] < 0) ? -p[i] : p[i]) * mm / mx;
				p[i] = (p[i] < 0) ? -mg : mg;
			end
		end
		w.fl = power_t'(p[0]);
		w.fr = power_t'(p[1]);
		w.bl = power_t'(p[2]);
		w.br = power_t'(p[3]);
		return w;
	endfunction

	task automatic check_wheel(string label, power_t want, power_t got);
		if (want !== got) begin
			err_count++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, label, want, got);
		end
	endtask

	always @(posedge clk) begin : wheel_checker
		wheel_cmd_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_wheels.size() == 0) begin
				err_count++;
				$display("%0t unexpected word: expected none actual %0d %0d %0d %0d",
					$time, front_left, front_right, back_left, back_right);
			end else begin
				want = expected_wheels.pop_front();
				check_wheel("front_left", want.fl, front_left);
				check_wheel("front_right", want.fr, front_right);
				check_wheel("back_left", want.bl, back_left);
				check_wheel("back_right", want.br, back_right);
			end
		end
	end

	// receiver: random stall, or a counted hold-off when requested
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_axes(axis_t f, axis_t s, axis_t t);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			fwd_axis <= axis_t'($urandom);
			side_axis <= axis_t'($urandom);
			turn_axis <= axis_t'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		fwd_axis <= f;
		side_axis <= s;
		turn_axis <= t;
		do @(posedge clk); while (in_stall);
		expected_wheels.push_back(mix_predict(f, s, t));
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_wheels.size() != 0)
			@(posedge clk);
		repeat (PIPE_STAGES + 4) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, cfg_val_t val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_JOY_DEADBAND:   mix_cfg.joy_deadband = val;
			REG_JOY_FULL_SCALE: mix_cfg.joy_full_scale = val;
			REG_POWER_LIMIT:    mix_cfg.power_limit = val;
			REG_DRIVE_MAX:      mix_cfg.drive_max = val;
			REG_STRAFE_MAX:     mix_cfg.strafe_max = val;
			REG_ROTATE_MAX:     mix_cfg.rotate_max = val;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// read back
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_W-1:0] !== val) begin
			err_count++;
			$display("%0t register %s readback: expected %0d actual %0d",
				$time, idx.name(), val, prdata[CFG_W-1:0]);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_load(cfg_val_t db, cfg_val_t fs, cfg_val_t mm,
			cfg_val_t dm, cfg_val_t sm, cfg_val_t rm);
		cfg_write(REG_JOY_DEADBAND, db);
		cfg_write(REG_JOY_FULL_SCALE, fs);
		cfg_write(REG_POWER_LIMIT, mm);
		cfg_write(REG_DRIVE_MAX, dm);
		cfg_write(REG_STRAFE_MAX, sm);
		cfg_write(REG_ROTATE_MAX, rm);
	endtask

	task automatic cfg_randomize();
		int db, fs;
		db = ($urandom_range(3) == 0) ? $urandom_range(126) : $urandom_range(40);
		fs = $urandom_range(127, db + 1);
		if ($urandom_range(7) == 0)
			fs = $urandom_range((db > 0) ? db : 1, 1);
		cfg_load(cfg_val_t'(db), cfg_val_t'(fs), cfg_val_t'($urandom_range(127, 1)),
			cfg_val_t'($urandom_range(127)), cfg_val_t'($urandom_range(127)),
			cfg_val_t'($urandom_range(127)));
	endtask

	// extremes, values inside and around the deadband, around full scale; half uniform
	function automatic axis_t pick_axis();
		int v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: v = -128;
					1: v = 127;
					2: v = -127;
					default: v = 0;
				endcase
			end
			1, 2: v = int'(mix_cfg.joy_deadband) + int'($urandom_range(4)) - 2;
			3: v = int'(mix_cfg.joy_full_scale) + int'($urandom_range(4)) - 2;
			4: v = int'($urandom_range(int'(mix_cfg.joy_deadband)));
			default: v = int'($urandom_range(255));
		endcase
		if (v < 128 && $urandom_range(1))
			v = -v;
		return axis_t'(v);
	endfunction

	task automatic test_default_mix();
		send_axes(0, 0, 0);
		send_axes(127, 0, 0);
		send_axes(-128, 0, 0);
		send_axes(0, 127, 0);
		send_axes(0, 0, -128);
		send_axes(9, -9, 10);
		send_axes(11, -11, 127);
		send_axes(127, 127, 127);
		send_axes(-128, -128, -128);
		send_axes(-128, 127, -1);
		send_axes(64, -64, 32);
		drain_pipeline();
	endtask

	task automatic test_corner_configs();
		// zero span
		cfg_write(REG_JOY_DEADBAND, 7'd50);
		cfg_write(REG_JOY_FULL_SCALE, 7'd50);
		send_axes(50, -50, 49);
		send_axes(51, -51, 0);
		drain_pipeline();
		// deadband above full scale
		cfg_write(REG_JOY_DEADBAND, 7'd100);
		cfg_write(REG_JOY_FULL_SCALE, 7'd40);
		send_axes(99, -100, 40);
		send_axes(-128, 101, -99);
		drain_pipeline();
		// zero motor limit
		cfg_write(REG_POWER_LIMIT, 7'd0);
		send_axes(127, -128, 60);
		drain_pipeline();
		cfg_load(7'd0, 7'd127, 7'd127, 7'd0, 7'd127, 7'd127);
		send_axes(127, 127, -128);
		send_axes(1, -1, 1);
		send_axes(-128, -128, 127);
		drain_pipeline();
		cfg_load(7'd126, 7'd127, 7'd1, 7'd127, 7'd127, 7'd127);
		send_axes(127, -127, 126);
		send_axes(125, -128, 0);
		drain_pipeline();
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 8; ph++) begin
			drain_pipeline();
			if (ph == 0)
				cfg_load(7'd0, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127);
			else if (ph == 1)
				cfg_load(7'd126, 7'd127, 7'd1, 7'd127, 7'd0, 7'd127);
			else
				cfg_randomize();
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 79; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 79; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			repeat (170) send_axes(pick_axis(), pick_axis(), pick_axis());
		end
		drain_pipeline();
	endtask

	task automatic test_backpressure();
		cfg_randomize();
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 150;
		repeat (100) send_axes(pick_axis(), pick_axis(), pick_axis());
		idle_pct = 20;
		stall_pct = 20;
		repeat (40) send_axes(pick_axis(), pick_axis(), pick_axis());
		drain_pipeline();
		repeat (30) send_axes(pick_axis(), pick_axis(), pick_axis());
		drain_pipeline();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		fwd_axis = '0;
		side_axis = '0;
		turn_axis = '0;
		out_stall = 1'b0;
		mix_cfg = CFG_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_mix();
		test_corner_configs();
		test_random_traffic();
		test_backpressure();

		if (err_count == 0 && expected_wheels.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[mecanum_drive_mixer.f]
hdl/mdm_pkg.sv
hdl/mdm_div.sv
hdl/mdm_axis_lane.sv
hdl/mdm_mixer.sv
hdl/mdm_norm_lane.sv
hdl/mecanum_drive_mixer.sv
test/tb_top.sv
